// ===== sv/dsa_pkg.sv =====
// package for the descriptor slot allocator: sizes, codes and types
// used by descriptor_slot_allocator_unit
`timescale 1ns / 1ps
package dsa_pkg;
  localparam int MaxSlots  = 1024;
  localparam int Frames    = 3;
  localparam int IdxW      = $clog2(MaxSlots);
  localparam int CntW      = IdxW + 1;
  localparam int FrW       = 2;
  localparam int AddrW     = 48;
  localparam int StrideW   = 16;
  localparam int DefDepth  = Frames * MaxSlots;
  localparam int DefAw     = $clog2(DefDepth);

  localparam logic [1:0] FuncAlloc   = 2'd0;
  localparam logic [1:0] FuncFree    = 2'd1;
  localparam logic [1:0] FuncRelease = 2'd2;
  localparam logic [1:0] FuncNone    = 2'd3;

  localparam logic [2:0] StOk      = 3'd0;
  localparam logic [2:0] StFull    = 3'd1;
  localparam logic [2:0] StBadAddr = 3'd2;
  localparam logic [2:0] StNull    = 3'd3;
  localparam logic [2:0] StFrame   = 3'd4;
  localparam logic [2:0] StNone    = 3'd5;

  localparam logic [2:0] RegCapacity = 3'd0;
  localparam logic [2:0] RegStride   = 3'd1;
  localparam logic [2:0] RegCpuBase  = 3'd2;
  localparam logic [2:0] RegGpuBase  = 3'd3;
  localparam logic [2:0] RegShader   = 3'd4;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_ARD, S_AMUL, S_DIV, S_FCHK, S_RRD, S_RWR, S_OUT
  } state_t;
endpackage

// ===== sv/descriptor_slot_allocator_unit.sv =====
// descriptor slot allocator top level: free stack, deferred lists, sequencer
// depends on dsa_pkg
`timescale 1ns / 1ps
// One item at a time. After reset, and after every capacity write, a pass over
// every slot refills the free stack (no item accepted then). Allocate pops a
// slot and runs a 16-bit shift-add multiply of index by stride, and skips the
// multiply when the heap is full; free computes one restoring quotient bit per
// cycle over the 48-bit offset, and skips the divide when rejected before it;
// release does one store read and one stack write per drained index; an unused
// func goes straight to the result. The result waits in an output register
// until taken; the next item is accepted once it has gone. Register writes are
// taken only while idle with no result waiting, and win over an item offered in
// the same cycle.
module descriptor_slot_allocator_unit import dsa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // handle_address[47:0], frame[49:48], zero
  input  logic [1:0]  in_tuser,   // func
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [119:0] out_tdata, // cpu_address, gpu_address, slot_index, released_count, zero
  output logic [2:0]  out_tuser,  // status
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [47:0] cfg_data
);
  logic [IdxW-1:0] stack_mem [MaxSlots];
  logic [IdxW-1:0] def_mem [DefDepth];

  state_t state_r, state_nxt;
  logic [CntW-1:0] cap_r, in_use_r, clr_r, k_r, n_r;
  logic [CntW-1:0] dcnt_r [Frames];
  logic [StrideW-1:0] stride_r;
  logic [AddrW-1:0] cpu_base_r, gpu_base_r;
  logic shader_r;
  logic [1:0] func_r;
  logic [FrW-1:0] frame_r;
  logic [AddrW-1:0] rem_r, quo_r, acc_r;
  logic [5:0] step_r;
  logic [IdxW-1:0] slot_r, rd_r;
  logic [2:0] st_r;
  logic [CntW-1:0] rel_r;
  logic ovalid_r;
  logic [AddrW-1:0] res_cpu_r, res_gpu_r;
  logic [IdxW-1:0] res_idx_r;
  logic [CntW-1:0] res_rel_r;

  logic [AddrW:0] trial;
  logic [CntW+1:0] queued;
  logic frame_ok;

  assign cfg_ready = (state_r == S_IDLE) && !ovalid_r;
  assign in_tready = (state_r == S_IDLE) && !ovalid_r && !cfg_valid;
  assign out_tvalid = ovalid_r;
  assign out_tuser = st_r;
  assign frame_ok = frame_r < FrW'(Frames);
  assign trial = {rem_r[AddrW-1:0], quo_r[AddrW-1]} - {{(AddrW-StrideW+1){1'b0}}, stride_r};

  always_comb begin
    queued = '0;
    for (int f = 0; f < Frames; f++) queued = queued + (CntW+2)'(dcnt_r[f]);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == CntW'(MaxSlots - 1)) state_nxt = S_IDLE;
      S_IDLE: begin
        if (cfg_valid && cfg_ready && cfg_index == RegCapacity) state_nxt = S_CLEAR;
        else if (in_tvalid && in_tready) begin
          case (in_tuser)
            FuncAlloc:   state_nxt = S_ARD;
            FuncFree:    state_nxt = S_FCHK;
            FuncRelease: state_nxt = S_RRD;
            default:     state_nxt = S_OUT;
          endcase
        end
      end
      S_ARD:  state_nxt = (in_use_r >= cap_r) ? S_OUT : S_AMUL;
      S_AMUL: if (step_r == 6'(StrideW - 1)) state_nxt = S_OUT;
      S_FCHK: begin
        if (rem_r == '0 || !frame_ok || queued >= (CntW+2)'(in_use_r) ||
            rem_r < cpu_base_r || stride_r == '0) state_nxt = S_OUT;
        else state_nxt = S_DIV;
      end
      S_DIV:  if (step_r == 6'(AddrW)) state_nxt = S_OUT;
      S_RRD:  state_nxt = (!frame_ok || k_r >= n_r || in_use_r == '0) ? S_OUT : S_RWR;
      S_RWR:  state_nxt = S_RRD;
      S_OUT:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    rd_r <= stack_mem[in_use_r[IdxW-1:0]];
    if (state_r == S_CLEAR) stack_mem[clr_r[IdxW-1:0]] <= clr_r[IdxW-1:0];
    else if (state_r == S_RWR) stack_mem[in_use_r[IdxW-1:0] - 1'b1] <= slot_r;
  end

  always_ff @(posedge clk) begin
    slot_r <= def_mem[DefAw'(frame_r) * DefAw'(MaxSlots) + DefAw'(k_r[IdxW-1:0])];
    if (state_r == S_DIV && step_r == 6'(AddrW) && rem_r == '0 &&
        quo_r < AddrW'(cap_r) && dcnt_r[frame_r] < CntW'(MaxSlots))
      def_mem[DefAw'(frame_r) * DefAw'(MaxSlots) + DefAw'(dcnt_r[frame_r][IdxW-1:0])]
        <= quo_r[IdxW-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
      clr_r <= '0;
      cap_r <= CntW'(MaxSlots);
      stride_r <= StrideW'(32);
      cpu_base_r <= '0;
      gpu_base_r <= '0;
      shader_r <= 1'b0;
      in_use_r <= '0;
      for (int f = 0; f < Frames; f++) dcnt_r[f] <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (ovalid_r && out_tready) ovalid_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          RegCapacity: begin
            if (cfg_data[CntW-1:0] == '0) cap_r <= CntW'(1);
            else if (cfg_data[CntW-1:0] > CntW'(MaxSlots)) cap_r <= CntW'(MaxSlots);
            else cap_r <= cfg_data[CntW-1:0];
            in_use_r <= '0;
            clr_r <= '0;
            for (int f = 0; f < Frames; f++) dcnt_r[f] <= '0;
          end
          RegStride:  stride_r <= cfg_data[StrideW-1:0];
          RegCpuBase: cpu_base_r <= cfg_data;
          RegGpuBase: gpu_base_r <= cfg_data;
          RegShader:  shader_r <= cfg_data[0];
          default: ;
        endcase
      end
      case (state_r)
        S_CLEAR: clr_r <= clr_r + 1'b1;
        S_IDLE: if (in_tvalid && in_tready) begin
          func_r <= in_tuser;
          frame_r <= in_tdata[49:48];
          rem_r <= in_tdata[AddrW-1:0];
          k_r <= '0;
          n_r <= dcnt_r[in_tdata[49:48]];
          rel_r <= '0;
          step_r <= '0;
          acc_r <= '0;
          st_r <= (in_tuser == FuncFree || in_tuser == FuncRelease ||
                   in_tuser == FuncAlloc) ? StOk : StNull;
        end
        S_ARD: begin
          if (in_use_r >= cap_r) st_r <= StFull;
          else begin
            // popped slot, held while the read port moves on
            quo_r <= AddrW'(rd_r);
            in_use_r <= in_use_r + 1'b1;
          end
        end
        S_AMUL: begin
          // shift-add, stride bits from the top
          acc_r <= (acc_r << 1) + (stride_r[StrideW-1-step_r[3:0]] ? quo_r : '0);
          step_r <= step_r + 1'b1;
        end
        S_FCHK: begin
          if (rem_r == '0) st_r <= StNull;
          else if (!frame_ok) st_r <= StFrame;
          else if (queued >= (CntW+2)'(in_use_r)) st_r <= StNone;
          else if (rem_r < cpu_base_r || stride_r == '0) st_r <= StBadAddr;
          else begin
            quo_r <= rem_r - cpu_base_r;
            rem_r <= '0;
          end
        end
        S_DIV: begin
          if (step_r == 6'(AddrW)) begin
            if (rem_r != '0 || quo_r >= AddrW'(cap_r)) st_r <= StBadAddr;
            else if (dcnt_r[frame_r] < CntW'(MaxSlots))
              dcnt_r[frame_r] <= dcnt_r[frame_r] + 1'b1;
          end else begin
            if (!trial[AddrW]) begin
              rem_r <= trial[AddrW-1:0];
              quo_r <= {quo_r[AddrW-2:0], 1'b1};
            end else begin
              rem_r <= {rem_r[AddrW-2:0], quo_r[AddrW-1]};
              quo_r <= {quo_r[AddrW-2:0], 1'b0};
            end
            step_r <= step_r + 1'b1;
          end
        end
        S_RRD: begin
          if (!frame_ok) st_r <= StFrame;
          else if (k_r >= n_r || in_use_r == '0) dcnt_r[frame_r] <= '0;
        end
        S_RWR: begin
          in_use_r <= in_use_r - 1'b1;
          k_r <= k_r + 1'b1;
          rel_r <= rel_r + 1'b1;
        end
        S_OUT: ovalid_r <= 1'b1;
        default: ;
      endcase
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    if (state_r == S_OUT) begin
      if (func_r == FuncAlloc && st_r == StOk) begin
        res_cpu_r <= cpu_base_r + acc_r;
        res_gpu_r <= shader_r ? gpu_base_r + acc_r : '0;
      end else begin
        res_cpu_r <= '0;
        res_gpu_r <= '0;
      end
      res_idx_r <= (st_r == StOk && (func_r == FuncAlloc || func_r == FuncFree)) ?
                   quo_r[IdxW-1:0] : '0;
      res_rel_r <= (func_r == FuncRelease && st_r == StOk) ? rel_r : '0;
    end
  end
  assign out_tdata = {3'b0, res_rel_r, res_idx_r, res_gpu_r, res_cpu_r};
endmodule
